@@ rtl/core/lpl_pkg.sv @@
package lpl_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int GAIN_W    = 24;
    localparam int LA_W      = 10;
    localparam int STAMP_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int GAIN_FRAC = 23;
    localparam int DIV_STEPS = 23;
    localparam int DIV_CNT_W = 5;

    localparam logic [GAIN_W-1:0] UNITY_GAIN = 24'h800000;

    localparam logic [CFG_IDX_W-1:0] CFG_LOOKAHEAD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 2'd2;

    localparam logic [LA_W-1:0]   LOOKAHEAD_RST = 10'd240;
    localparam logic [GAIN_W-1:0] CEILING_RST   = 24'h800000;
    localparam logic [GAIN_W-1:0] RELEASE_RST   = 24'd1748;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_POP_RD,
        ST_POP_CHK,
        ST_PUSH,
        ST_EXP_RD,
        ST_EXP_CHK,
        ST_DIV_INIT,
        ST_DIV,
        ST_GAIN,
        ST_MUL_L,
        ST_MUL_R,
        ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_CAPTURE,
        OP_POP_RD,
        OP_POP_CHK,
        OP_PUSH,
        OP_EXP_RD,
        OP_EXP_CHK,
        OP_DIV_INIT,
        OP_DIV,
        OP_GAIN,
        OP_MUL_L,
        OP_MUL_R,
        OP_OUT
    } op_t;

    typedef struct packed {
        logic clear_last;
        logic dq_empty;
        logic pop_hit;
        logic exp_hit;
        logic need_div;
        logic div_last;
        logic out_free;
    } sts_t;

endpackage

@@ rtl/core/lpl_ram.sv @@
module lpl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/lpl_ctrl.sv @@
module lpl_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  lpl_pkg::sts_t sts,
    output lpl_pkg::op_t  op
);
    import lpl_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        unique case (state_reg)
            ST_CLEAR:
            begin
                op = OP_CLEAR;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op         = OP_CAPTURE;
                    state_next = ST_POP_RD;
                end
            end
            ST_POP_RD:
            begin
                if (sts.dq_empty)
                begin
                    state_next = ST_PUSH;
                end
                else
                begin
                    op         = OP_POP_RD;
                    state_next = ST_POP_CHK;
                end
            end
            ST_POP_CHK:
            begin
                op         = OP_POP_CHK;
                state_next = sts.pop_hit ? ST_POP_RD : ST_PUSH;
            end
            ST_PUSH:
            begin
                op         = OP_PUSH;
                state_next = ST_EXP_RD;
            end
            ST_EXP_RD:
            begin
                op         = OP_EXP_RD;
                state_next = ST_EXP_CHK;
            end
            ST_EXP_CHK:
            begin
                op         = OP_EXP_CHK;
                state_next = sts.exp_hit ? ST_EXP_RD : ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                op         = OP_DIV_INIT;
                state_next = sts.need_div ? ST_DIV : ST_GAIN;
            end
            ST_DIV:
            begin
                op = OP_DIV;
                if (sts.div_last)
                begin
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN:
            begin
                op         = OP_GAIN;
                state_next = ST_MUL_L;
            end
            ST_MUL_L:
            begin
                op         = OP_MUL_L;
                state_next = ST_MUL_R;
            end
            ST_MUL_R:
            begin
                op         = OP_MUL_R;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (sts.out_free)
                begin
                    op         = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

@@ rtl/core/lpl_datapath.sv @@
module lpl_datapath #(
    parameter int MAX_LOOKAHEAD = 512
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  lpl_pkg::op_t                          op,
    output lpl_pkg::sts_t                         sts,
    input  logic                                  cfg_we,
    input  logic [lpl_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [lpl_pkg::GAIN_W-1:0]            cfg_data,
    input  logic signed [lpl_pkg::SAMPLE_W-1:0]   sample_left,
    input  logic signed [lpl_pkg::SAMPLE_W-1:0]   sample_right,
    input  logic                                  last_in_block,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [lpl_pkg::SAMPLE_W-1:0]   out_left,
    output logic signed [lpl_pkg::SAMPLE_W-1:0]   out_right,
    output logic [lpl_pkg::GAIN_W-1:0]            gain_now,
    output logic [lpl_pkg::GAIN_W-1:0]            block_min_gain,
    output logic                                  block_done
);
    import lpl_pkg::*;

    localparam int CAP   = MAX_LOOKAHEAD + 2;
    localparam int DQ_AW = $clog2(CAP);
    localparam int DQ_CW = $clog2(CAP + 1);
    localparam int DL_AW = $clog2(MAX_LOOKAHEAD);
    localparam int LEN_W = $clog2(MAX_LOOKAHEAD + 1);
    localparam int DQ_DW = GAIN_W + STAMP_W;
    localparam int DL_DW = 2 * SAMPLE_W;
    localparam int PROD_W = SAMPLE_W + GAIN_W + 1;

    // configuration
    logic [LA_W-1:0]   lookahead_reg;
    logic [GAIN_W-1:0] ceiling_reg;
    logic [GAIN_W-1:0] release_reg;

    // frame state
    logic [STAMP_W-1:0] frame_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic [GAIN_W-1:0]  bmin_reg;
    logic [DQ_AW-1:0]   head_reg;
    logic [DQ_CW-1:0]   count_reg;
    logic [DL_AW-1:0]   pos_reg;
    logic [DL_AW-1:0]   clr_reg;

    // per-item work registers
    logic signed [SAMPLE_W-1:0] xl_reg, xr_reg;
    logic signed [SAMPLE_W-1:0] dl_reg, dr_reg;
    logic [GAIN_W-1:0]          peak_reg;
    logic [STAMP_W-1:0]         k_reg;
    logic                       last_reg;
    logic [GAIN_W-1:0]          wmax_reg;
    logic                       need_div_reg;
    logic [GAIN_W-1:0]          rem_reg;
    logic [DIV_STEPS-1:0]       quo_reg;
    logic [DIV_CNT_W-1:0]       div_cnt_reg;
    logic [GAIN_W-1:0]          gnew_reg;
    logic [GAIN_W-1:0]          rep_min_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [SAMPLE_W-1:0] resl_reg;

    // output register
    logic                       ovalid_reg;
    logic signed [SAMPLE_W-1:0] oleft_reg, oright_reg;
    logic [GAIN_W-1:0]          ogain_reg, omin_reg;
    logic                       odone_reg;

    // combinational
    logic [LEN_W-1:0]   len;
    logic [GAIN_W-1:0]  abs_l, abs_r;
    logic [DQ_CW:0]     back_sum, slot_sum;
    logic [DQ_AW-1:0]   back_idx, slot_idx, head_inc, head_push;
    logic [DQ_CW-1:0]   count_push;
    logic [DQ_AW-1:0]   dq_raddr;
    logic [DQ_DW-1:0]   dq_rdata;
    logic [GAIN_W-1:0]  rd_peak;
    logic [STAMP_W-1:0] rd_stamp;
    logic [STAMP_W-1:0] age;
    logic [DL_AW-1:0]   dl_addr;
    logic [LEN_W-1:0]   dl_inc;
    logic [DL_AW-1:0]   pos_after;
    logic               dl_we;
    logic [DL_AW-1:0]   dl_waddr;
    logic [DL_DW-1:0]   dl_wdata;
    logic [DL_DW-1:0]   dl_rdata;
    logic [GAIN_W:0]    rem_sh;
    logic [GAIN_W:0]    gain_sum;
    logic [GAIN_W-1:0]  target;
    logic [GAIN_W-1:0]  gain_sel;
    logic [GAIN_W-1:0]  bmin_sel;
    logic signed [PROD_W-1:0] mul_a_g;

    always_comb
    begin
        if ({22'd0, lookahead_reg} > 32'(MAX_LOOKAHEAD))
        begin
            len = LEN_W'(MAX_LOOKAHEAD);
        end
        else if (lookahead_reg == '0)
        begin
            len = LEN_W'(1);
        end
        else
        begin
            len = LEN_W'(lookahead_reg);
        end
    end

    assign abs_l = sample_left[SAMPLE_W-1]  ? GAIN_W'(-sample_left)  : GAIN_W'(sample_left);
    assign abs_r = sample_right[SAMPLE_W-1] ? GAIN_W'(-sample_right) : GAIN_W'(sample_right);

    // circular deque indexing
    always_comb
    begin
        back_sum = (DQ_CW+1)'(head_reg) + (DQ_CW+1)'(count_reg) - (DQ_CW+1)'(1);
        if (back_sum >= (DQ_CW+1)'(CAP))
        begin
            back_sum = back_sum - (DQ_CW+1)'(CAP);
        end
        back_idx = DQ_AW'(back_sum);

        head_inc = (head_reg == DQ_AW'(CAP - 1)) ? '0 : head_reg + DQ_AW'(1);
        if (count_reg >= DQ_CW'(CAP))
        begin
            head_push  = head_inc;
            count_push = count_reg - DQ_CW'(1);
        end
        else
        begin
            head_push  = head_reg;
            count_push = count_reg;
        end
        slot_sum = (DQ_CW+1)'(head_push) + (DQ_CW+1)'(count_push);
        if (slot_sum >= (DQ_CW+1)'(CAP))
        begin
            slot_sum = slot_sum - (DQ_CW+1)'(CAP);
        end
        slot_idx = DQ_AW'(slot_sum);
    end

    assign dq_raddr = (op == OP_POP_RD) ? back_idx : head_reg;
    assign rd_peak  = dq_rdata[DQ_DW-1:STAMP_W];
    assign rd_stamp = dq_rdata[STAMP_W-1:0];
    assign age      = k_reg - rd_stamp;

    lpl_ram #(
        .WIDTH(DQ_DW),
        .DEPTH(CAP)
    ) u_deque (
        .clk  (clk),
        .we   (op == OP_PUSH),
        .waddr(slot_idx),
        .wdata({peak_reg, k_reg}),
        .raddr(dq_raddr),
        .rdata(dq_rdata)
    );

    // delay line, both channels side by side
    assign dl_addr   = (LEN_W'(pos_reg) >= len) ? '0 : pos_reg;
    assign dl_inc    = LEN_W'(dl_addr) + LEN_W'(1);
    assign pos_after = (dl_inc == len) ? '0 : DL_AW'(dl_inc);

    always_comb
    begin
        dl_we    = 1'b0;
        dl_waddr = dl_addr;
        dl_wdata = {xl_reg, xr_reg};
        if (op == OP_CLEAR)
        begin
            dl_we    = 1'b1;
            dl_waddr = clr_reg;
            dl_wdata = '0;
        end
        else if (op == OP_EXP_CHK && !sts.exp_hit)
        begin
            dl_we = 1'b1;
        end
    end

    lpl_ram #(
        .WIDTH(DL_DW),
        .DEPTH(MAX_LOOKAHEAD)
    ) u_delay (
        .clk  (clk),
        .we   (dl_we),
        .waddr(dl_waddr),
        .wdata(dl_wdata),
        .raddr(dl_addr),
        .rdata(dl_rdata)
    );

    // restoring divider step, one quotient bit per cycle
    assign rem_sh = {rem_reg, 1'b0};

    assign target   = need_div_reg ? GAIN_W'(quo_reg) : UNITY_GAIN;
    assign gain_sum = {1'b0, gain_reg} + {1'b0, release_reg};
    assign gain_sel = (gain_sum > {1'b0, target}) ? target : gain_sum[GAIN_W-1:0];
    assign bmin_sel = (gain_sel < bmin_reg) ? gain_sel : bmin_reg;

    assign mul_a_g = ((op == OP_MUL_L) ? dl_reg : dr_reg) * $signed({1'b0, gnew_reg});

    always_comb
    begin
        sts.clear_last = (clr_reg == DL_AW'(MAX_LOOKAHEAD - 1));
        sts.dq_empty   = (count_reg == '0);
        sts.pop_hit    = (rd_peak <= peak_reg);
        sts.exp_hit    = (count_reg != '0) && (age > STAMP_W'(len));
        sts.need_div   = (wmax_reg > ceiling_reg);
        sts.div_last   = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
        sts.out_free   = !ovalid_reg || !out_stall;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lookahead_reg <= LOOKAHEAD_RST;
            ceiling_reg   <= CEILING_RST;
            release_reg   <= RELEASE_RST;
            frame_reg     <= '0;
            gain_reg      <= UNITY_GAIN;
            bmin_reg      <= UNITY_GAIN;
            head_reg      <= '0;
            count_reg     <= '0;
            pos_reg       <= '0;
            clr_reg       <= '0;
            div_cnt_reg   <= '0;
            ovalid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_LOOKAHEAD: lookahead_reg <= cfg_data[LA_W-1:0];
                    CFG_CEILING:   ceiling_reg   <= cfg_data;
                    CFG_RELEASE:   release_reg   <= cfg_data;
                    default:       ;
                endcase
            end
            if (ovalid_reg && !out_stall)
            begin
                ovalid_reg <= 1'b0;
            end
            unique case (op)
                OP_CLEAR:
                begin
                    clr_reg <= clr_reg + DL_AW'(1);
                end
                OP_CAPTURE:
                begin
                    frame_reg <= frame_reg + STAMP_W'(1);
                end
                OP_POP_CHK:
                begin
                    if (sts.pop_hit)
                    begin
                        count_reg <= count_reg - DQ_CW'(1);
                    end
                end
                OP_PUSH:
                begin
                    head_reg  <= head_push;
                    count_reg <= count_push + DQ_CW'(1);
                end
                OP_EXP_CHK:
                begin
                    if (sts.exp_hit)
                    begin
                        head_reg  <= head_inc;
                        count_reg <= count_reg - DQ_CW'(1);
                    end
                    else
                    begin
                        pos_reg <= pos_after;
                    end
                end
                OP_DIV_INIT:
                begin
                    div_cnt_reg <= '0;
                end
                OP_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
                end
                OP_GAIN:
                begin
                    gain_reg <= gain_sel;
                    bmin_reg <= last_reg ? UNITY_GAIN : bmin_sel;
                end
                OP_OUT:
                begin
                    ovalid_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        unique case (op)
            OP_CAPTURE:
            begin
                xl_reg   <= sample_left;
                xr_reg   <= sample_right;
                peak_reg <= (abs_l > abs_r) ? abs_l : abs_r;
                k_reg    <= frame_reg;
                last_reg <= last_in_block;
            end
            OP_EXP_CHK:
            begin
                wmax_reg <= rd_peak;
                dl_reg   <= dl_rdata[DL_DW-1:SAMPLE_W];
                dr_reg   <= dl_rdata[SAMPLE_W-1:0];
            end
            OP_DIV_INIT:
            begin
                need_div_reg <= sts.need_div;
                rem_reg      <= ceiling_reg;
                quo_reg      <= '0;
            end
            OP_DIV:
            begin
                if (rem_sh >= {1'b0, wmax_reg})
                begin
                    rem_reg <= GAIN_W'(rem_sh - {1'b0, wmax_reg});
                    quo_reg <= {quo_reg[DIV_STEPS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[GAIN_W-1:0];
                    quo_reg <= {quo_reg[DIV_STEPS-2:0], 1'b0};
                end
            end
            OP_GAIN:
            begin
                gnew_reg    <= gain_sel;
                rep_min_reg <= last_reg ? bmin_sel : '0;
            end
            OP_MUL_L:
            begin
                prod_reg <= mul_a_g;
            end
            OP_MUL_R:
            begin
                resl_reg <= prod_reg[GAIN_FRAC+SAMPLE_W-1:GAIN_FRAC];
                prod_reg <= mul_a_g;
            end
            OP_OUT:
            begin
                oleft_reg  <= resl_reg;
                oright_reg <= prod_reg[GAIN_FRAC+SAMPLE_W-1:GAIN_FRAC];
                ogain_reg  <= gnew_reg;
                omin_reg   <= rep_min_reg;
                odone_reg  <= last_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid      = ovalid_reg;
    assign out_left       = oleft_reg;
    assign out_right      = oright_reg;
    assign gain_now       = ogain_reg;
    assign block_min_gain = omin_reg;
    assign block_done     = odone_reg;

endmodule

@@ rtl/core/lookahead_peak_limiter.sv @@
// steps per frame: capture, pop deque entries not above the new peak, push, expire old entries,
// divide only when the window peak exceeds the ceiling, gain, multiply left and right, output
// one frame at a time: in_stall stays high from capture until the result enters the output register
// output register lets the next frame enter while a result waits to be taken
// reset: async active low; control state and control registers to defaults, payload registers not reset
// after reset the delay memory is zeroed, one entry a cycle, all MAX_LOOKAHEAD entries
module lookahead_peak_limiter #(
    parameter int MAX_LOOKAHEAD = 512
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lpl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lpl_pkg::GAIN_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [lpl_pkg::SAMPLE_W-1:0] sample_left,
    input  logic signed [lpl_pkg::SAMPLE_W-1:0] sample_right,
    input  logic                                last_in_block,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [lpl_pkg::SAMPLE_W-1:0] out_left,
    output logic signed [lpl_pkg::SAMPLE_W-1:0] out_right,
    output logic [lpl_pkg::GAIN_W-1:0]          gain_now,
    output logic [lpl_pkg::GAIN_W-1:0]          block_min_gain,
    output logic                                block_done
);
    import lpl_pkg::*;

    op_t  op;
    sts_t sts;

    assign cfg_ready = 1'b1;

    lpl_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .sts     (sts),
        .op      (op)
    );

    lpl_datapath #(
        .MAX_LOOKAHEAD(MAX_LOOKAHEAD)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .op            (op),
        .sts           (sts),
        .cfg_we        (cfg_valid & cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .sample_left   (sample_left),
        .sample_right  (sample_right),
        .last_in_block (last_in_block),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_left      (out_left),
        .out_right     (out_right),
        .gain_now      (gain_now),
        .block_min_gain(block_min_gain),
        .block_done    (block_done)
    );

endmodule

@@ tb/sv/lookahead_peak_limiter_test.sv @@
`timescale 1ns / 100ps

module lookahead_peak_limiter_test;
    import lpl_pkg::*;

    localparam int  MAX_LA      = 512;
    localparam int  DQ_SLOTS    = MAX_LA + 2;
    localparam int  DRAIN_WAIT  = 1300;
    localparam int  CYCLE_LIMIT = 2000000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
        logic [GAIN_W-1:0]   gain;
        logic [GAIN_W-1:0]   bmin;
        logic                done;
    } frame_t;

    class limiter_scoreboard;
        frame_t      expected_frames[$];
        int          errors;
        int          la_reg;
        longint      ceiling;
        longint      rel_step;
        longint      delay_line[2][MAX_LA];
        int          delay_pos;
        longint      dq_peak[DQ_SLOTS];
        int unsigned dq_stamp[DQ_SLOTS];
        int          dq_head;
        int          dq_count;
        int unsigned frame_no;
        longint      gain;
        longint      block_low;

        function new();
            errors    = 0;
            la_reg    = LOOKAHEAD_RST;
            ceiling   = CEILING_RST;
            rel_step  = RELEASE_RST;
            delay_pos = 0;
            dq_head   = 0;
            dq_count  = 0;
            frame_no  = 0;
            gain      = UNITY_GAIN;
            block_low = UNITY_GAIN;
            foreach (delay_line[c, i]) delay_line[c][i] = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
            case (idx)
                CFG_LOOKAHEAD: la_reg = val[LA_W-1:0];
                CFG_CEILING:   ceiling = val;
                CFG_RELEASE:   rel_step = val;
                default: ;
            endcase
        endfunction

        function void note_frame(logic signed [SAMPLE_W-1:0] l,
                                 logic signed [SAMPLE_W-1:0] r, logic last);
            longint      x[2];
            longint      peak;
            longint      wmax;
            longint      target;
            longint      g;
            longint      prod;
            int          len;
            int          slot;
            int unsigned k;
            int unsigned age;
            frame_t      f;
            x[0] = l;
            x[1] = r;
            k = frame_no;
            frame_no = frame_no + 1;
            len = (la_reg == 0) ? 1 : (la_reg > MAX_LA ? MAX_LA : la_reg);
            peak = 0;
            for (int c = 0; c < 2; c++)
            begin
                if ((x[c] < 0 ? -x[c] : x[c]) > peak)
                    peak = x[c] < 0 ? -x[c] : x[c];
            end
            // monotonic deque of peaks over the window
            while (dq_count > 0 && dq_peak[(dq_head + dq_count - 1) % DQ_SLOTS] <= peak)
                dq_count--;
            if (dq_count >= DQ_SLOTS)
            begin
                dq_head = (dq_head + 1) % DQ_SLOTS;
                dq_count--;
            end
            slot = (dq_head + dq_count) % DQ_SLOTS;
            dq_peak[slot] = peak;
            dq_stamp[slot] = k;
            dq_count++;
            while (dq_count > 0)
            begin
                age = k - dq_stamp[dq_head];
                if (age <= len)
                    break;
                dq_head = (dq_head + 1) % DQ_SLOTS;
                dq_count--;
            end
            wmax = dq_peak[dq_head];
            target = (wmax > ceiling) ? (ceiling << GAIN_FRAC) / wmax : longint'(UNITY_GAIN);
            g = gain + rel_step;
            if (g > target)
                g = target;
            gain = g;
            if (g < block_low)
                block_low = g;
            if (delay_pos >= len)
                delay_pos = 0;
            prod = (delay_line[0][delay_pos] * g) >>> GAIN_FRAC;
            f.left = prod[SAMPLE_W-1:0];
            prod = (delay_line[1][delay_pos] * g) >>> GAIN_FRAC;
            f.right = prod[SAMPLE_W-1:0];
            delay_line[0][delay_pos] = x[0];
            delay_line[1][delay_pos] = x[1];
            delay_pos = (delay_pos + 1) % len;
            f.gain = g[GAIN_W-1:0];
            if (last)
            begin
                f.bmin = block_low[GAIN_W-1:0];
                f.done = 1'b1;
                block_low = UNITY_GAIN;
            end
            else
            begin
                f.bmin = '0;
                f.done = 1'b0;
            end
            expected_frames.push_back(f);
        endfunction

        function void check_frame(frame_t got);
            frame_t want;
            if (expected_frames.size() == 0)
            begin
                $display("%0t: unexpected result left=%h right=%h gain=%h", $time,
                         got.left, got.right, got.gain);
                errors++;
                return;
            end
            want = expected_frames.pop_front();
            if (got.left !== want.left)
            begin
                $display("%0t: out_left expected %h actual %h", $time, want.left, got.left);
                errors++;
            end
            if (got.right !== want.right)
            begin
                $display("%0t: out_right expected %h actual %h", $time, want.right, got.right);
                errors++;
            end
            if (got.gain !== want.gain)
            begin
                $display("%0t: gain_now expected %h actual %h", $time, want.gain, got.gain);
                errors++;
            end
            if (got.bmin !== want.bmin)
            begin
                $display("%0t: block_min_gain expected %h actual %h", $time, want.bmin,
                         got.bmin);
                errors++;
            end
            if (got.done !== want.done)
            begin
                $display("%0t: block_done expected %b actual %b", $time, want.done, got.done);
                errors++;
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [GAIN_W-1:0]          cfg_data;
    logic                       in_valid;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample_left;
    logic signed [SAMPLE_W-1:0] sample_right;
    logic                       last_in_block;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
    logic [GAIN_W-1:0]          gain_now;
    logic [GAIN_W-1:0]          block_min_gain;
    logic                       block_done;

    limiter_scoreboard limiter_sb;
    bit                no_idle;
    int                cycles;

    lookahead_peak_limiter u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sample_left    (sample_left),
        .sample_right   (sample_right),
        .last_in_block  (last_in_block),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_left       (out_left),
        .out_right      (out_right),
        .gain_now       (gain_now),
        .block_min_gain (block_min_gain),
        .block_done     (block_done)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // result side: random stall, check every accepted result
    always @(posedge clk)
    begin
        frame_t got;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            got.left  = out_left;
            got.right = out_right;
            got.gain  = gain_now;
            got.bmin  = block_min_gain;
            got.done  = block_done;
            limiter_sb.check_frame(got);
        end
        out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 10);
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        limiter_sb.write_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_frame(logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r, logic last);
        int gap;
        in_valid      <= 1'b1;
        sample_left   <= l;
        sample_right  <= r;
        last_in_block <= last;
        do
            @(posedge clk);
        while (in_stall);
        limiter_sb.note_frame(l, r, last);
        gap = 0;
        if (!no_idle && $urandom_range(99) < 10)
            gap = $urandom_range(1, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (limiter_sb.expected_frames.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return $urandom_range(1) ? 24'h800000 : 24'h7fffff;
            1:       return 24'h000000;
            2, 3:    return SAMPLE_W'($urandom_range(0, 4000) - 2000);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic random_phase(int n, logic [GAIN_W-1:0] la, logic [GAIN_W-1:0] ceil,
                                logic [GAIN_W-1:0] step);
        logic [SAMPLE_W-1:0] l;
        write_reg(CFG_LOOKAHEAD, la);
        write_reg(CFG_CEILING, ceil);
        write_reg(CFG_RELEASE, step);
        for (int i = 0; i < n; i++)
        begin
            // random samples, some with both channels equal, drive attack and release
            if ($urandom_range(3) == 0)
            begin
                l = pick_sample();
                send_frame(l, $urandom_range(1) ? l : pick_sample(), $urandom_range(7) == 0);
            end
            else
                send_frame(pick_sample(), pick_sample(), $urandom_range(7) == 0);
        end
        drain();
    endtask

    initial
    begin
        limiter_sb    = new();
        cycles        = 0;
        no_idle       = 1'b0;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        sample_left   = '0;
        sample_right  = '0;
        last_in_block = 1'b0;
        out_stall     = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults for a few frames first, then a short window for the extremes
        send_frame(24'h7fffff, 24'h800000, 1'b0);
        send_frame(24'h000001, 24'hffffff, 1'b1);
        drain();
        write_reg(CFG_UNUSED, 24'h000005);
        write_reg(CFG_LOOKAHEAD, 24'd2);
        write_reg(CFG_CEILING, 24'h400000);
        write_reg(CFG_RELEASE, 24'd1748);
        send_frame(24'h7fffff, 24'h000000, 1'b0);
        send_frame(24'h000000, 24'h800000, 1'b0);
        send_frame(24'hffffff, 24'h000001, 1'b1);
        send_frame(24'h000000, 24'h000000, 1'b1);
        send_frame(24'h800000, 24'h800000, 1'b0);
        send_frame(24'h3fffff, 24'hc00001, 1'b0);
        send_frame(24'h400001, 24'h000000, 1'b1);
        send_frame(24'h000000, 24'h000000, 1'b0);
        send_frame(24'h000000, 24'h000000, 1'b0);
        send_frame(24'h000000, 24'h000000, 1'b1);
        send_frame(24'h555555, 24'haaaaaa, 1'b1);
        drain();
        // zero ceiling: silent frames leave the target at unity, a nonzero frame pulls the gain to zero
        write_reg(CFG_CEILING, 24'h000000);
        send_frame(24'h000000, 24'h000000, 1'b0);
        send_frame(24'h000010, 24'h000000, 1'b0);
        send_frame(24'h000000, 24'h000000, 1'b0);
        send_frame(24'h000000, 24'h000000, 1'b0);
        send_frame(24'h000000, 24'h000000, 1'b1);
        drain();
        // shrink window below the current write position
        write_reg(CFG_LOOKAHEAD, 24'd5);
        write_reg(CFG_CEILING, 24'hffffff);
        send_frame(24'h7fffff, 24'h123456, 1'b0);
        send_frame(24'h800000, 24'h654321, 1'b0);
        send_frame(24'h100000, 24'h000000, 1'b0);
        drain();
        write_reg(CFG_LOOKAHEAD, 24'd1);
        send_frame(24'h000002, 24'h000003, 1'b1);
        send_frame(24'h000004, 24'h000005, 1'b1);
        drain();

        random_phase(90, 24'd1, 24'h800000, 24'd1);
        random_phase(90, 24'd0, 24'h000000, 24'h800000);
        no_idle = 1'b1;
        random_phase(90, 24'd3, 24'h000001, 24'hffffff);
        no_idle = 1'b0;
        random_phase(90, 24'd33, 24'd3000000, 24'd20000);
        random_phase(90, 24'd1023, 24'hffffff, 24'd100000);
        random_phase(60, 24'd512, 24'd6000000, 24'd1748);
        random_phase(40, 24'd17, 24'd1, 24'd1);

        if (limiter_sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/lpl_pkg.sv
rtl/core/lpl_ram.sv
rtl/core/lpl_ctrl.sv
rtl/core/lpl_datapath.sv
rtl/core/lookahead_peak_limiter.sv
tb/sv/lookahead_peak_limiter_test.sv
